>>> rtl/owtsr_pkg.sv
// Package for the single-wire temperature sensor reader core.
// Field widths, register indexes, reset defaults, status codes and the command table.
// No dependencies.
package owtsr_pkg;

    // Configuration register widths
    localparam int RESET_LOW_W  = 12;
    localparam int PRES_WAIT_W  = 12;
    localparam int RECOVERY_W   = 12;
    localparam int SLOT_W       = 8;
    localparam int CONV_WAIT_W  = 20;
    localparam int TIMER_W      = 20;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_ADDR_W   = 3;
    localparam int TEMP_W       = 16;
    localparam int STATUS_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RESET_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRES_WAIT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RECOVERY   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_SLOT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_SLOT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CONV_WAIT  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [RESET_LOW_W-1:0] RESET_LOW_DEF  = 12'd500;
    localparam logic [PRES_WAIT_W-1:0] PRES_WAIT_DEF  = 12'd70;
    localparam logic [RECOVERY_W-1:0]  RECOVERY_DEF   = 12'd500;
    localparam logic [SLOT_W-1:0]      SHORT_SLOT_DEF = 8'd7;
    localparam logic [SLOT_W-1:0]      LONG_SLOT_DEF  = 8'd70;
    localparam logic [CONV_WAIT_W-1:0] CONV_WAIT_DEF  = 20'd0;

    // Sequence status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STUCK    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_PRES  = 2'd2;

    // Request kinds on the input tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

    // Command byte sent at each of the four write steps
    function automatic logic [7:0] cmd_byte(input logic [1:0] step);
        logic [7:0] b;
        unique case (step)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SCR;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/onewire_temp_sensor_reader_core.sv
// Single-wire bus master that reads a temperature sensor, stepped by microsecond ticks.
// Results go to the output register in the next cycle after an input is accepted.
// Throughput: one transaction per cycle unless the result channel stalls (m_tready low);
// a single pass of the phase sequencer per item. Reset (aresetn, synchronous, active low)
// clears the sequencer to idle, the last status and temperature to zero and the
// configuration registers to their defaults. Depends on owtsr_pkg.
module onewire_temp_sensor_reader_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] bus_level, [7:1] zero
    input  logic        s_tuser,   // [0] req_type
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] bus_drive_low, [1] busy_res, [3:2] status,
                                   // [19:4] temperature, [23:20] zero
    output logic        m_tlast,   // done_res
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [owtsr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [owtsr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_CHECK,
        PH_RST_LOW,
        PH_PRES_WAIT,
        PH_RECOVERY,
        PH_W_LOW,
        PH_W_HIGH,
        PH_R_LOW,
        PH_R_WAIT,
        PH_R_REC,
        PH_CONV
    } phase_t;

    // Configuration registers
    logic [owtsr_pkg::RESET_LOW_W-1:0] reset_low_reg;
    logic [owtsr_pkg::PRES_WAIT_W-1:0] pres_wait_reg;
    logic [owtsr_pkg::RECOVERY_W-1:0]  recovery_reg;
    logic [owtsr_pkg::SLOT_W-1:0]      short_slot_reg;
    logic [owtsr_pkg::SLOT_W-1:0]      long_slot_reg;
    logic [owtsr_pkg::CONV_WAIT_W-1:0] conv_wait_reg;

    // Sequencer state
    phase_t                            phase_reg,       phase_next;
    logic [owtsr_pkg::TIMER_W-1:0]     timer_reg,       timer_next;
    logic [2:0]                        bit_count_reg,   bit_count_next;
    logic [2:0]                        byte_step_reg,   byte_step_next;
    logic [7:0]                        shift_reg,       shift_next;
    logic [7:0]                        scratch_reg,     scratch_next;
    logic [owtsr_pkg::STATUS_W-1:0]    status_reg,      status_next;
    logic [owtsr_pkg::TEMP_W-1:0]      temp_reg,        temp_next;
    logic                              no_pres_reg,     no_pres_next;

    // Output register
    logic                              m_valid_reg;
    logic                              drive_low_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic                              accept;
    logic                              req;
    logic                              level;
    logic                              expired;
    logic [owtsr_pkg::TIMER_W-1:0]     timer_dec;
    logic                              done_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req      = s_tuser;
    assign level    = s_tdata[0];

    // Timer expiry: a count of one or less ends the wait
    assign expired   = (timer_reg <= owtsr_pkg::TIMER_W'(1));
    assign timer_dec = expired ? '0 : timer_reg - owtsr_pkg::TIMER_W'(1);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg  <= owtsr_pkg::RESET_LOW_DEF;
            pres_wait_reg  <= owtsr_pkg::PRES_WAIT_DEF;
            recovery_reg   <= owtsr_pkg::RECOVERY_DEF;
            short_slot_reg <= owtsr_pkg::SHORT_SLOT_DEF;
            long_slot_reg  <= owtsr_pkg::LONG_SLOT_DEF;
            conv_wait_reg  <= owtsr_pkg::CONV_WAIT_DEF;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                owtsr_pkg::REG_RESET_LOW:  reset_low_reg  <= cfg_wdata[owtsr_pkg::RESET_LOW_W-1:0];
                owtsr_pkg::REG_PRES_WAIT:  pres_wait_reg  <= cfg_wdata[owtsr_pkg::PRES_WAIT_W-1:0];
                owtsr_pkg::REG_RECOVERY:   recovery_reg   <= cfg_wdata[owtsr_pkg::RECOVERY_W-1:0];
                owtsr_pkg::REG_SHORT_SLOT: short_slot_reg <= cfg_wdata[owtsr_pkg::SLOT_W-1:0];
                owtsr_pkg::REG_LONG_SLOT:  long_slot_reg  <= cfg_wdata[owtsr_pkg::SLOT_W-1:0];
                owtsr_pkg::REG_CONV_WAIT:  conv_wait_reg  <= cfg_wdata[owtsr_pkg::CONV_WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state for one transaction
    always_comb begin
        logic start_byte;
        logic start_slot;
        logic bit_done;

        start_byte     = 1'b0;
        start_slot     = 1'b0;
        bit_done       = 1'b0;
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_count_next = bit_count_reg;
        byte_step_next = byte_step_reg;
        shift_next     = shift_reg;
        scratch_next   = scratch_reg;
        status_next    = status_reg;
        temp_next      = temp_reg;
        no_pres_next   = no_pres_reg;
        done_next      = 1'b0;

        if (req == owtsr_pkg::REQ_START) begin
            // Start is ignored while a sequence runs
            if (phase_reg == PH_IDLE) begin
                phase_next     = PH_RST_CHECK;
                byte_step_next = '0;
                bit_count_next = '0;
                timer_next     = '0;
                shift_next     = '0;
                no_pres_next   = 1'b0;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_RST_CHECK: begin
                    if (!level) begin
                        phase_next   = PH_IDLE;
                        status_next  = owtsr_pkg::STAT_STUCK;
                        temp_next    = '0;
                        scratch_next = '0;
                        done_next    = 1'b1;
                    end else begin
                        phase_next = PH_RST_LOW;
                        timer_next = owtsr_pkg::TIMER_W'(reset_low_reg);
                    end
                end
                PH_RST_LOW: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        phase_next = PH_PRES_WAIT;
                        timer_next = owtsr_pkg::TIMER_W'(pres_wait_reg);
                    end
                end
                PH_PRES_WAIT: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        no_pres_next = level;
                        phase_next   = PH_RECOVERY;
                        timer_next   = owtsr_pkg::TIMER_W'(recovery_reg);
                    end
                end
                PH_RECOVERY: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        if (no_pres_reg) begin
                            phase_next   = PH_IDLE;
                            status_next  = owtsr_pkg::STAT_NO_PRES;
                            temp_next    = '0;
                            scratch_next = '0;
                            done_next    = 1'b1;
                        end else begin
                            start_byte = 1'b1;
                        end
                    end
                end
                PH_W_LOW: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        phase_next = PH_W_HIGH;
                        timer_next = shift_reg[0] ? owtsr_pkg::TIMER_W'(long_slot_reg)
                                                  : owtsr_pkg::TIMER_W'(short_slot_reg);
                    end
                end
                PH_W_HIGH: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bit_done   = 1'b1;
                    end
                end
                PH_R_LOW: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        phase_next = PH_R_WAIT;
                        timer_next = owtsr_pkg::TIMER_W'(short_slot_reg);
                    end
                end
                PH_R_WAIT: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        // LSB first: sampled bit enters at the top
                        shift_next = {level, shift_reg[7:1]};
                        phase_next = PH_R_REC;
                        timer_next = owtsr_pkg::TIMER_W'(long_slot_reg);
                    end
                end
                PH_R_REC: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        bit_done = 1'b1;
                    end
                end
                PH_CONV: begin
                    timer_next = timer_dec;
                    if (expired) begin
                        phase_next = PH_RST_CHECK;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        // End of a bit slot; a wrapped count means the byte is complete
        if (bit_done) begin
            bit_count_next = bit_count_reg + 3'd1;
            if (bit_count_next == 3'd0) begin
                priority if (byte_step_reg == 3'd1) begin
                    // Convert sent: wait unless conv_wait is zero, then the second reset
                    byte_step_next = 3'd2;
                    if (conv_wait_reg == '0) begin
                        phase_next = PH_RST_CHECK;
                    end else begin
                        phase_next = PH_CONV;
                        timer_next = conv_wait_reg;
                    end
                end else if (byte_step_reg == 3'd4) begin
                    scratch_next   = shift_next;
                    byte_step_next = 3'd5;
                    start_byte     = 1'b1;
                end else if (byte_step_reg >= 3'd5) begin
                    phase_next   = PH_IDLE;
                    status_next  = owtsr_pkg::STAT_OK;
                    temp_next    = {shift_next, scratch_reg};
                    scratch_next = '0;
                    done_next    = 1'b1;
                end else begin
                    byte_step_next = byte_step_reg + 3'd1;
                    start_byte     = 1'b1;
                end
            end else begin
                start_slot = 1'b1;
            end
        end

        // Load the next byte: a command while writing, zero while reading
        if (start_byte) begin
            bit_count_next = '0;
            shift_next     = (byte_step_next < 3'd4) ? owtsr_pkg::cmd_byte(byte_step_next[1:0])
                                                     : 8'd0;
            start_slot     = 1'b1;
        end

        // Open a write or read slot
        if (start_slot) begin
            if (byte_step_next < 3'd4) begin
                phase_next = PH_W_LOW;
                timer_next = shift_next[0] ? owtsr_pkg::TIMER_W'(short_slot_reg)
                                           : owtsr_pkg::TIMER_W'(long_slot_reg);
            end else begin
                phase_next = PH_R_LOW;
                timer_next = owtsr_pkg::TIMER_W'(short_slot_reg);
            end
        end
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_count_reg <= '0;
            byte_step_reg <= '0;
            shift_reg     <= '0;
            scratch_reg   <= '0;
            status_reg    <= '0;
            temp_reg      <= '0;
            no_pres_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            drive_low_reg <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
                bit_count_reg <= bit_count_next;
                byte_step_reg <= byte_step_next;
                shift_reg     <= shift_next;
                scratch_reg   <= scratch_next;
                status_reg    <= status_next;
                temp_reg      <= temp_next;
                no_pres_reg   <= no_pres_next;
                drive_low_reg <= (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW)
                                 || (phase_next == PH_R_LOW);
                busy_reg      <= (phase_next != PH_IDLE);
                done_reg      <= done_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {4'd0, temp_reg, status_reg, busy_reg, drive_low_reg};

endmodule

>>> sim/onewire_temp_sensor_reader_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for onewire_temp_sensor_reader_core: a bit-accurate predictor of
// the bus sequencer checks every result transaction, field by field, under random idling.
// Depends on owtsr_pkg and the core RTL.
module onewire_temp_sensor_reader_core_tb;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_ITEMS    = 950;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_MARGIN    = 10;
    localparam int MAX_REPORTS     = 100;

    // Indexes with no register behind them
    localparam logic [owtsr_pkg::CFG_ADDR_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [owtsr_pkg::CFG_ADDR_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RST_CHK, ST_RST_LOW, ST_PRES_WAIT, ST_RECOVERY,
        ST_WR_LOW, ST_WR_HIGH, ST_RD_LOW, ST_RD_WAIT, ST_RD_REC, ST_CONV
    } bus_phase_t;

    typedef struct packed {
        logic                                  drive_low;
        logic                                  busy;
        logic                                  done;
        logic [owtsr_pkg::STATUS_W-1:0]        status;
        logic signed [owtsr_pkg::TEMP_W-1:0]   temperature;
    } sensor_result_t;

    // DUT inputs, all known from time zero
    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic [7:0]                       s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             m_tready  = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [owtsr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [owtsr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_tready;
    logic                             m_tvalid;
    logic [23:0]                      m_tdata;   // [0] bus_drive_low, [1] busy_res,
                                                 // [3:2] status, [19:4] temperature
    logic                             m_tlast;   // done_res

    // Register mirror
    logic [owtsr_pkg::RESET_LOW_W-1:0] reset_low_ticks = owtsr_pkg::RESET_LOW_DEF;
    logic [owtsr_pkg::PRES_WAIT_W-1:0] pres_wait_ticks = owtsr_pkg::PRES_WAIT_DEF;
    logic [owtsr_pkg::RECOVERY_W-1:0]  recovery_ticks  = owtsr_pkg::RECOVERY_DEF;
    logic [owtsr_pkg::SLOT_W-1:0]      short_ticks     = owtsr_pkg::SHORT_SLOT_DEF;
    logic [owtsr_pkg::SLOT_W-1:0]      long_ticks      = owtsr_pkg::LONG_SLOT_DEF;
    logic [owtsr_pkg::CONV_WAIT_W-1:0] conv_ticks      = owtsr_pkg::CONV_WAIT_DEF;

    // Predicted sequencer state
    bus_phase_t                     seq_phase   = ST_IDLE;
    logic [owtsr_pkg::TIMER_W-1:0]  seq_timer   = '0;
    logic [2:0]                     bit_cnt     = '0;
    logic [2:0]                     byte_step   = '0;
    logic [7:0]                     shift_reg   = '0;
    logic [7:0]                     scratch_low = '0;
    logic [owtsr_pkg::STATUS_W-1:0] last_status = owtsr_pkg::STAT_OK;
    logic [owtsr_pkg::TEMP_W-1:0]   last_temp   = '0;
    logic                           no_presence = 1'b0;
    logic                           done_flag   = 1'b0;

    sensor_result_t expected_q[$];
    int  err_count     = 0;
    int  results_seen  = 0;
    int  useful_items  = 0;
    int  cycle_count   = 0;
    bit  idle_on       = 1'b0;
    bit  hold_off_req  = 1'b0;

    always #10 aclk = ~aclk;

    onewire_temp_sensor_reader_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------- predictor

    function automatic void seq_finish(input logic [owtsr_pkg::STATUS_W-1:0] st,
                                       input logic [owtsr_pkg::TEMP_W-1:0] temp);
        seq_phase   = ST_IDLE;
        last_status = st;
        last_temp   = temp;
        scratch_low = '0;
        done_flag   = 1'b1;
    endfunction

    // Counts one tick off the phase timer; a count of 0 or 1 ends the phase
    function automatic bit timer_done();
        if (seq_timer <= 1) begin
            seq_timer = '0;
            return 1'b1;
        end
        seq_timer = seq_timer - 1'b1;
        return 1'b0;
    endfunction

    function automatic void start_slot();
        if (byte_step < 3'd4) begin
            seq_phase = ST_WR_LOW;
            seq_timer = shift_reg[0] ? owtsr_pkg::TIMER_W'(short_ticks)
                                     : owtsr_pkg::TIMER_W'(long_ticks);
        end else begin
            seq_phase = ST_RD_LOW;
            seq_timer = owtsr_pkg::TIMER_W'(short_ticks);
        end
    endfunction

    function automatic void start_byte();
        bit_cnt = '0;
        case (byte_step)
            3'd0, 3'd2: shift_reg = owtsr_pkg::CMD_SKIP_ROM;
            3'd1:       shift_reg = owtsr_pkg::CMD_CONVERT;
            3'd3:       shift_reg = owtsr_pkg::CMD_READ_SCR;
            default:    shift_reg = 8'h00;
        endcase
        start_slot();
    endfunction

    // End of a bit slot; at the end of a byte, move on to the next step of the sequence
    function automatic void bit_done();
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt != 3'd0) begin
            start_slot();
        end else if (byte_step == 3'd1) begin
            byte_step = 3'd2;
            if (conv_ticks == '0) begin
                seq_phase = ST_RST_CHK;
            end else begin
                seq_phase = ST_CONV;
                seq_timer = conv_ticks;
            end
        end else if (byte_step == 3'd4) begin
            scratch_low = shift_reg;
            byte_step   = 3'd5;
            start_byte();
        end else if (byte_step >= 3'd5) begin
            seq_finish(owtsr_pkg::STAT_OK, {shift_reg, scratch_low});
        end else begin
            byte_step = byte_step + 3'd1;
            start_byte();
        end
    endfunction

    function automatic sensor_result_t next_result(input logic req, input logic level);
        sensor_result_t r;
        done_flag = 1'b0;
        if (req == owtsr_pkg::REQ_START) begin
            if (seq_phase == ST_IDLE) begin
                seq_phase   = ST_RST_CHK;
                byte_step   = '0;
                bit_cnt     = '0;
                seq_timer   = '0;
                shift_reg   = '0;
                no_presence = 1'b0;
            end
        end else if (seq_phase != ST_IDLE) begin
            case (seq_phase)
                ST_RST_CHK: begin
                    if (!level) begin
                        seq_finish(owtsr_pkg::STAT_STUCK, '0);
                    end else begin
                        seq_phase = ST_RST_LOW;
                        seq_timer = owtsr_pkg::TIMER_W'(reset_low_ticks);
                    end
                end
                ST_RST_LOW: if (timer_done()) begin
                    seq_phase = ST_PRES_WAIT;
                    seq_timer = owtsr_pkg::TIMER_W'(pres_wait_ticks);
                end
                ST_PRES_WAIT: if (timer_done()) begin
                    no_presence = level;
                    seq_phase   = ST_RECOVERY;
                    seq_timer   = owtsr_pkg::TIMER_W'(recovery_ticks);
                end
                ST_RECOVERY: if (timer_done()) begin
                    if (no_presence) seq_finish(owtsr_pkg::STAT_NO_PRES, '0);
                    else start_byte();
                end
                ST_WR_LOW: if (timer_done()) begin
                    seq_phase = ST_WR_HIGH;
                    seq_timer = shift_reg[0] ? owtsr_pkg::TIMER_W'(long_ticks)
                                             : owtsr_pkg::TIMER_W'(short_ticks);
                end
                ST_WR_HIGH: if (timer_done()) begin
                    shift_reg = shift_reg >> 1;
                    bit_done();
                end
                ST_RD_LOW: if (timer_done()) begin
                    seq_phase = ST_RD_WAIT;
                    seq_timer = owtsr_pkg::TIMER_W'(short_ticks);
                end
                ST_RD_WAIT: if (timer_done()) begin
                    shift_reg = {level, shift_reg[7:1]};
                    seq_phase = ST_RD_REC;
                    seq_timer = owtsr_pkg::TIMER_W'(long_ticks);
                end
                ST_RD_REC:  if (timer_done()) bit_done();
                ST_CONV:    if (timer_done()) seq_phase = ST_RST_CHK;
                default:    seq_phase = ST_IDLE;
            endcase
        end
        r.drive_low   = (seq_phase == ST_RST_LOW) || (seq_phase == ST_WR_LOW) ||
                        (seq_phase == ST_RD_LOW);
        r.busy        = (seq_phase != ST_IDLE);
        r.done        = done_flag;
        r.status      = last_status;
        r.temperature = last_temp;
        return r;
    endfunction

    // ---------------------------------------------------------------- common tasks

    task automatic report_error(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One input transaction; valid stays high when the next one follows at once
    task automatic send_item(input logic req, input logic level);
        sensor_result_t want;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, level};
        do @(posedge aclk); while (!s_tready);
        if ((req == owtsr_pkg::REQ_START) == (seq_phase == ST_IDLE)) useful_items++;
        want = next_result(req, level);
        expected_q.push_back(want);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender stops until every outstanding result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic write_reg(input logic [owtsr_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [owtsr_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (addr)
            owtsr_pkg::REG_RESET_LOW:  reset_low_ticks = data[owtsr_pkg::RESET_LOW_W-1:0];
            owtsr_pkg::REG_PRES_WAIT:  pres_wait_ticks = data[owtsr_pkg::PRES_WAIT_W-1:0];
            owtsr_pkg::REG_RECOVERY:   recovery_ticks  = data[owtsr_pkg::RECOVERY_W-1:0];
            owtsr_pkg::REG_SHORT_SLOT: short_ticks     = data[owtsr_pkg::SLOT_W-1:0];
            owtsr_pkg::REG_LONG_SLOT:  long_ticks      = data[owtsr_pkg::SLOT_W-1:0];
            owtsr_pkg::REG_CONV_WAIT:  conv_ticks      = data[owtsr_pkg::CONV_WAIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int rst_low, input int pres, input int rec,
                             input int short_slot, input int long_slot, input int conv);
        write_reg(owtsr_pkg::REG_RESET_LOW,  owtsr_pkg::CFG_DATA_W'(rst_low));
        write_reg(owtsr_pkg::REG_PRES_WAIT,  owtsr_pkg::CFG_DATA_W'(pres));
        write_reg(owtsr_pkg::REG_RECOVERY,   owtsr_pkg::CFG_DATA_W'(rec));
        write_reg(owtsr_pkg::REG_SHORT_SLOT, owtsr_pkg::CFG_DATA_W'(short_slot));
        write_reg(owtsr_pkg::REG_LONG_SLOT,  owtsr_pkg::CFG_DATA_W'(long_slot));
        write_reg(owtsr_pkg::REG_CONV_WAIT,  owtsr_pkg::CFG_DATA_W'(conv));
    endtask

    // One start request followed by ticks until the predicted sequence ends.
    // stuck_check: which pre-reset check sees the bus low (0 = neither).
    // presence: whether a device answers; read_word is returned unless rand_read.
    task automatic measure(input int stuck_check, input bit presence, input bit rand_read,
                           input logic [15:0] read_word);
        int checks;
        int bit_idx;
        logic lvl;
        checks = 0;
        send_item(owtsr_pkg::REQ_START, 1'($urandom_range(0, 1)));
        while (seq_phase != ST_IDLE) begin
            if ($urandom_range(0, 199) == 0) wait_drained();
            if ($urandom_range(0, 49) == 0) begin
                // start while busy, to be ignored
                send_item(owtsr_pkg::REQ_START, 1'($urandom_range(0, 1)));
            end else begin
                lvl = 1'($urandom_range(0, 1));
                case (seq_phase)
                    ST_RST_CHK: begin
                        checks++;
                        lvl = (checks != stuck_check);
                    end
                    ST_PRES_WAIT: if (seq_timer <= 1) lvl = !presence;
                    ST_RD_WAIT: if (!rand_read && seq_timer <= 1) begin
                        bit_idx = (byte_step == 3'd5) ? 8 + bit_cnt : bit_cnt;
                        lvl = read_word[bit_idx];
                    end
                    default: ;
                endcase
                send_item(owtsr_pkg::REQ_TICK, lvl);
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Ticks while idle, a start while busy, bus stuck low at the first check
    task automatic test_idle_and_start_rules();
        send_item(owtsr_pkg::REQ_TICK, 1'b0);
        send_item(owtsr_pkg::REQ_TICK, 1'b1);
        send_item(owtsr_pkg::REQ_START, 1'b1);
        send_item(owtsr_pkg::REQ_START, 1'b0);
        send_item(owtsr_pkg::REQ_TICK, 1'b0);
        send_item(owtsr_pkg::REQ_TICK, 1'b1);
        send_item(owtsr_pkg::REQ_TICK, 1'b0);
        wait_drained();
    endtask

    // Timing left at its reset values: the bus is stuck low at the first check
    task automatic test_reset_defaults();
        measure(1, 1'b1, 1'b1, '0);
        wait_drained();
    endtask

    // All counts zero: each phase lasts one tick, conversion wait skipped until it is set to 1
    task automatic test_zero_durations();
        write_all(0, 0, 0, 0, 0, 0);
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, owtsr_pkg::CFG_DATA_W'(3));
        measure(0, 1'b1, 1'b0, 16'h8000);
        measure(0, 1'b1, 1'b0, 16'h7FFF);
        measure(2, 1'b1, 1'b1, '0);
        measure(0, 1'b0, 1'b1, '0);
        wait_drained();
        write_reg(owtsr_pkg::REG_CONV_WAIT, owtsr_pkg::CFG_DATA_W'(1));
        measure(0, 1'b1, 1'b0, 16'h5A3C);
        wait_drained();
    endtask

    // Largest counts: a bus stuck low at the first check ends the sequence at once
    task automatic test_extremes();
        write_all(4095, 4095, 4095, 255, 255, 1048575);
        measure(1, 1'b1, 1'b1, '0);
        wait_drained();
    endtask

    // Small random timing with stray register bits; random data and idling come from the caller
    task automatic random_config();
        logic [owtsr_pkg::CFG_DATA_W-1:0] junk;
        junk = owtsr_pkg::CFG_DATA_W'($urandom());
        write_reg(owtsr_pkg::REG_RESET_LOW,  {junk[19:12], 12'($urandom_range(0, 6))});
        write_reg(owtsr_pkg::REG_PRES_WAIT,  {junk[11:4], 12'($urandom_range(0, 4))});
        write_reg(owtsr_pkg::REG_RECOVERY,   {junk[7:0], 12'($urandom_range(0, 4))});
        write_reg(owtsr_pkg::REG_SHORT_SLOT, {junk[19:8], 8'($urandom_range(0, 2))});
        write_reg(owtsr_pkg::REG_LONG_SLOT,  {junk[11:0], 8'($urandom_range(0, 3))});
        write_reg(owtsr_pkg::REG_CONV_WAIT,
                  ($urandom_range(0, 2) == 0) ? '0
                                              : owtsr_pkg::CFG_DATA_W'($urandom_range(1, 8)));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, junk);
    endtask

    task automatic test_random_traffic();
        int seq_no;
        int r;
        seq_no = 0;
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            if (seq_no % 2 == 0) begin
                wait_drained();
                random_config();
            end
            idle_on = ($urandom_range(0, 9) != 0);
            repeat ($urandom_range(0, 3))
                send_item(owtsr_pkg::REQ_TICK, 1'($urandom_range(0, 1)));
            r = $urandom_range(0, 99);
            measure((r < 3) ? 1 : (r < 6) ? 2 : 0, !(r >= 6 && r < 10), 1'b1, '0);
            seq_no++;
        end
        idle_on = 1'b0;
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_all(2, 1, 2, 1, 2, 3);
        hold_off_req = 1'b1;
        measure(0, 1'b1, 1'b1, '0);
        wait_drained();
    endtask

    // ---------------------------------------------------------------- processes

    // Result receiver: random stalls, plus one long hold-off counted here
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        forever begin
            gap = idle_on ? pick_gap() : 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_checker
        sensor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_error($sformatf("result %0d with none expected", results_seen));
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[0] !== want.drive_low)
                    report_error($sformatf("result %0d bus_drive_low: got %0b, expected %0b",
                                           results_seen, m_tdata[0], want.drive_low));
                if (m_tdata[1] !== want.busy)
                    report_error($sformatf("result %0d busy: got %0b, expected %0b",
                                           results_seen, m_tdata[1], want.busy));
                if (m_tlast !== want.done)
                    report_error($sformatf("result %0d done: got %0b, expected %0b",
                                           results_seen, m_tlast, want.done));
                if (m_tdata[3:2] !== want.status)
                    report_error($sformatf("result %0d status: got %0d, expected %0d",
                                           results_seen, m_tdata[3:2], want.status));
                if (m_tdata[19:4] !== want.temperature)
                    report_error($sformatf("result %0d temperature: got %0d, expected %0d",
                                           results_seen, $signed(m_tdata[19:4]),
                                           want.temperature));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Test sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_and_start_rules();
        test_reset_defaults();
        test_zero_durations();
        test_extremes();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_MARGIN) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
